// ----- rtl/ihp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types, codes and helpers for the Intel HEX record parser.
// ----------------------------------------------------------------------------
package ihp_pkg;

  localparam int IMAGE_BYTES_DEF = 8192;
  localparam int LINE_CHARS_DEF  = 256;

  localparam logic [7:0] COLON_CHAR   = 8'd58;
  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  typedef logic [7:0]  char_t;
  typedef logic [12:0] waddr_t;
  typedef logic [13:0] ext_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_END     = 3'd1,
    ST_NOCOLON = 3'd2,
    ST_BADTYPE = 3'd3,
    ST_LONG    = 3'd4,
    ST_RANGE   = 3'd5,
    ST_SHORT   = 3'd6
  } status_t;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t   kind;
    waddr_t  write_address;
    char_t   write_data;
    status_t status;
    ext_t    image_extent;
  } rec_t;

  function automatic logic [3:0] nibble_of(input char_t c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) n = 4'(c - 8'd48);
    else if (c >= 8'd97 && c <= 8'd102) n = 4'(c - 8'd87);
    else if (c >= 8'd65 && c <= 8'd70) n = 4'(c - 8'd55);
    return n;
  endfunction

endpackage

// ----- rtl/ihp_if.sv -----
// ----------------------------------------------------------------------------
// ihp_char_if / ihp_rec_if
// Valid/ready channels for text characters and parser result words.
// ----------------------------------------------------------------------------
interface ihp_char_if;
  logic           valid;
  logic           ready;
  ihp_pkg::char_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ihp_rec_if;
  logic             valid;
  logic             ready;
  ihp_pkg::kind_t   kind;
  ihp_pkg::waddr_t  write_address;
  ihp_pkg::char_t   write_data;
  ihp_pkg::status_t status;
  ihp_pkg::ext_t    image_extent;

  modport source (output valid, output kind, output write_address, output write_data,
                  output status, output image_extent, input ready);
  modport sink   (input valid, input kind, input write_address, input write_data,
                  input status, input image_extent, output ready);
endinterface

// ----- rtl/intel_hex_record_parser_core.sv -----
// ----------------------------------------------------------------------------
// intel_hex_record_parser_core
// Each accepted character waits in the input character register, then its result
// word, if any, goes to the result register; one character per cycle unless a result
// word meets a stalled result channel, as the parse step is a single pass between the two.
// Reset (synchronous, rst_n low) returns the parser to the start of a line with
// cleared fields, zero extent and parsing active.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_core #(
  parameter int IMAGE_BYTES = ihp_pkg::IMAGE_BYTES_DEF,
  parameter int LINE_CHARS  = ihp_pkg::LINE_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ihp_char_if.sink  in_chan,
  ihp_rec_if.source out_chan
);

  localparam int PW = $clog2(LINE_CHARS);
  localparam int EW = $clog2(IMAGE_BYTES + 1);

  logic            s1_valid_r;
  ihp_pkg::char_t  s1_char_r;

  logic            stopped_r,  stopped_nxt;
  logic [PW-1:0]   pos_r,      pos_nxt;
  logic [3:0]      hi_nib_r,   hi_nib_nxt;
  logic [7:0]      cnt_r,      cnt_nxt;
  logic [15:0]     addr_r,     addr_nxt;
  logic [7:0]      rtype_r,    rtype_nxt;
  logic [EW-1:0]   ext_r,      ext_nxt;
  logic            rerr_r,     rerr_nxt;

  logic            res_valid;
  ihp_pkg::rec_t   res;
  logic            out_valid_r;
  ihp_pkg::rec_t   out_r;

  logic            out_free;
  logic            advance;

  ihp_step #(
    .IMAGE_BYTES (IMAGE_BYTES),
    .LINE_CHARS  (LINE_CHARS)
  ) u_step (
    .c           (s1_char_r),
    .stopped     (stopped_r),
    .pos         (pos_r),
    .hi_nib      (hi_nib_r),
    .cnt         (cnt_r),
    .addr        (addr_r),
    .rtype       (rtype_r),
    .ext         (ext_r),
    .rerr        (rerr_r),
    .stopped_nxt (stopped_nxt),
    .pos_nxt     (pos_nxt),
    .hi_nib_nxt  (hi_nib_nxt),
    .cnt_nxt     (cnt_nxt),
    .addr_nxt    (addr_nxt),
    .rtype_nxt   (rtype_nxt),
    .ext_nxt     (ext_nxt),
    .rerr_nxt    (rerr_nxt),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_free      = !out_valid_r || out_chan.ready;
  assign advance       = s1_valid_r && (out_free || !res_valid);
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char_r <= in_chan.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
      pos_r     <= '0;
      hi_nib_r  <= '0;
      cnt_r     <= '0;
      addr_r    <= '0;
      rtype_r   <= '0;
      ext_r     <= '0;
      rerr_r    <= 1'b0;
    end else if (advance) begin
      stopped_r <= stopped_nxt;
      pos_r     <= pos_nxt;
      hi_nib_r  <= hi_nib_nxt;
      cnt_r     <= cnt_nxt;
      addr_r    <= addr_nxt;
      rtype_r   <= rtype_nxt;
      ext_r     <= ext_nxt;
      rerr_r    <= rerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_r.kind;
  assign out_chan.write_address = out_r.write_address;
  assign out_chan.write_data    = out_r.write_data;
  assign out_chan.status        = out_r.status;
  assign out_chan.image_extent  = out_r.image_extent;

endmodule

// ----- rtl/ihp_step.sv -----
// ----------------------------------------------------------------------------
// ihp_step
// Per-character parse step: next parser state and the optional result word.
// ----------------------------------------------------------------------------
module ihp_step #(
  parameter int IMAGE_BYTES = ihp_pkg::IMAGE_BYTES_DEF,
  parameter int LINE_CHARS  = ihp_pkg::LINE_CHARS_DEF,
  localparam int PW = $clog2(LINE_CHARS),
  localparam int EW = $clog2(IMAGE_BYTES + 1)
) (
  input  ihp_pkg::char_t  c,
  input  logic            stopped,
  input  logic [PW-1:0]   pos,
  input  logic [3:0]      hi_nib,
  input  logic [7:0]      cnt,
  input  logic [15:0]     addr,
  input  logic [7:0]      rtype,
  input  logic [EW-1:0]   ext,
  input  logic            rerr,
  output logic            stopped_nxt,
  output logic [PW-1:0]   pos_nxt,
  output logic [3:0]      hi_nib_nxt,
  output logic [7:0]      cnt_nxt,
  output logic [15:0]     addr_nxt,
  output logic [7:0]      rtype_nxt,
  output logic [EW-1:0]   ext_nxt,
  output logic            rerr_nxt,
  output logic            res_valid,
  output ihp_pkg::rec_t   res
);

  localparam int IW = ((PW > 10) ? PW : 10) + 1;
  localparam int AW = 17;

  logic [IW-1:0] idx;
  logic [IW-1:0] cnt2;
  logic [IW-1:0] data_off;
  logic [7:0]    byte_val;
  logic [AW-1:0] byte_addr;
  logic [AW-1:0] end_addr;
  logic [AW-1:0] end_sat;
  ihp_pkg::status_t st;
  logic          st_en;

  assign idx       = IW'(pos);
  assign cnt2      = IW'({cnt, 1'b0});
  assign data_off  = (idx - IW'(10)) >> 1;
  assign byte_val  = {hi_nib, ihp_pkg::nibble_of(c)};
  assign byte_addr = AW'(addr) + AW'(data_off);
  assign end_addr  = AW'(addr) + AW'(cnt);
  assign end_sat   = (end_addr > AW'(IMAGE_BYTES)) ? AW'(IMAGE_BYTES) : end_addr;

  always_comb begin
    stopped_nxt = stopped;
    pos_nxt     = pos;
    hi_nib_nxt  = hi_nib;
    cnt_nxt     = cnt;
    addr_nxt    = addr;
    rtype_nxt   = rtype;
    ext_nxt     = ext;
    rerr_nxt    = rerr;
    st          = ihp_pkg::ST_OK;
    st_en       = 1'b0;
    res_valid   = 1'b0;
    res         = '0;
    if (!stopped) begin
      if (pos == PW'(LINE_CHARS - 1)) begin
        st    = ihp_pkg::ST_LONG;
        st_en = 1'b1;
      end else if (pos == '0) begin
        if (c != ihp_pkg::COLON_CHAR) begin
          st    = ihp_pkg::ST_NOCOLON;
          st_en = 1'b1;
        end else begin
          pos_nxt  = PW'(1);
          rerr_nxt = 1'b0;
        end
      end else if (c == ihp_pkg::NEWLINE_CHAR) begin
        pos_nxt = '0;
        st_en   = 1'b1;
        if (idx < (cnt2 + IW'(11))) st = ihp_pkg::ST_SHORT;
        else if (rtype == 8'd1)     st = ihp_pkg::ST_END;
        else if (rtype != 8'd0)     st = ihp_pkg::ST_BADTYPE;
        else if (rerr)              st = ihp_pkg::ST_RANGE;
        else begin
          st = ihp_pkg::ST_OK;
          if (end_sat > AW'(ext)) ext_nxt = EW'(end_sat);
        end
      end else begin
        pos_nxt = pos + PW'(1);
        if (pos[0]) begin
          hi_nib_nxt = ihp_pkg::nibble_of(c);
        end else if (idx == IW'(2)) begin
          cnt_nxt = byte_val;
        end else if (idx == IW'(4)) begin
          addr_nxt = {byte_val, addr[7:0]};
        end else if (idx == IW'(6)) begin
          addr_nxt = {addr[15:8], byte_val};
        end else if (idx == IW'(8)) begin
          rtype_nxt = byte_val;
        end else if (idx >= IW'(10) && idx < (cnt2 + IW'(10)) && rtype == 8'd0) begin
          if (byte_addr >= AW'(IMAGE_BYTES)) begin
            rerr_nxt = 1'b1;
          end else if (!rerr) begin
            res_valid         = 1'b1;
            res.kind          = ihp_pkg::KIND_WRITE;
            res.write_address = ihp_pkg::waddr_t'(byte_addr);
            res.write_data    = byte_val;
            res.status        = ihp_pkg::ST_OK;
            res.image_extent  = ihp_pkg::ext_t'(ext);
          end
        end
      end
      if (st_en) begin
        res_valid        = 1'b1;
        res.kind         = ihp_pkg::KIND_STATUS;
        res.status       = st;
        res.image_extent = ihp_pkg::ext_t'(ext_nxt);
        if (st != ihp_pkg::ST_OK) stopped_nxt = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ihp_checker.sv -----
// ----------------------------------------------------------------------------
// ihp_checker
// Port-level checks on the parser result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ihp_checker #(
  parameter int IMAGE_BYTES = ihp_pkg::IMAGE_BYTES_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input ihp_pkg::kind_t   kind,
  input ihp_pkg::waddr_t  write_address,
  input ihp_pkg::char_t   write_data,
  input ihp_pkg::status_t status,
  input ihp_pkg::ext_t    image_extent
);

  // an error or end record is the last word ever delivered
  a_stop_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && kind == ihp_pkg::KIND_STATUS && status != ihp_pkg::ST_OK
    |=> !out_valid)
    else $error("word after stopping status");

  a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(image_extent) <= 32'(IMAGE_BYTES) || IMAGE_BYTES > 16383)
    else $error("image extent beyond image size");

  a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == ihp_pkg::KIND_WRITE |-> status == ihp_pkg::ST_OK)
    else $error("write word carries a status");

  a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == ihp_pkg::KIND_STATUS |-> write_address == '0 && write_data == '0)
    else $error("status word carries write payload");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(write_address) && $stable(status))
    else $error("stalled word changed");

endmodule

bind intel_hex_record_parser_core ihp_checker #(
  .IMAGE_BYTES (IMAGE_BYTES)
) u_ihp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .kind          (out_chan.kind),
  .write_address (out_chan.write_address),
  .write_data    (out_chan.write_data),
  .status        (out_chan.status),
  .image_extent  (out_chan.image_extent)
);

// ----- dv/ihp_parser_checker.sv -----
// ----------------------------------------------------------------------------
// ihp_parser_checker
// Watches the character and result channels of the HEX record parser. It keeps
// its own copy of the line parse state, works out the result word that each
// accepted character causes, and compares every accepted result word field by
// field with the oldest one still due.
// ----------------------------------------------------------------------------
module ihp_parser_checker (
  input  logic clk,
  input  logic rst_n,
  ihp_char_if  in_chan,
  ihp_rec_if   out_chan,
  output int   fail_count,
  output int   words_due,
  output int   writes_seen,
  output int   status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IMAGE_BYTES = ihp_pkg::IMAGE_BYTES_DEF;
  localparam int LINE_CHARS  = ihp_pkg::LINE_CHARS_DEF;

  ihp_pkg::rec_t result_words_due[$];
  int   fails    = 0;
  int   due_n    = 0;
  int   writes   = 0;
  int   statuses = 0;

  logic [8:0]    line_pos   = '0;
  logic [3:0]    upper_nib  = '0;
  logic [7:0]    byte_count = '0;
  logic [15:0]   load_addr  = '0;
  logic [7:0]    rec_type   = '0;
  ihp_pkg::ext_t extent     = '0;
  logic          range_hit  = 1'b0;
  logic          halted     = 1'b0;

  assign fail_count  = fails;
  assign words_due   = due_n;
  assign writes_seen = writes;
  assign status_seen = statuses;

  function automatic logic [3:0] hex_value(input ihp_pkg::char_t c);
    if (c[7:4] == 4'h3 && c[3:0] <= 4'h9) return c[3:0];
    if ((c[7:4] == 4'h4 || c[7:4] == 4'h6) && c[3:0] >= 4'h1 && c[3:0] <= 4'h6)
      return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  task automatic post_status(input ihp_pkg::status_t code);
    result_words_due.push_back(ihp_pkg::rec_t'{kind: ihp_pkg::KIND_STATUS,
                                               write_address: '0, write_data: '0,
                                               status: code, image_extent: extent});
    if (code != ihp_pkg::ST_OK) halted = 1'b1;
  endtask

  task automatic parse_char(input ihp_pkg::char_t c);
    int idx;
    int pair;
    int addr;
    int line_end;
    idx = int'(line_pos);
    if (halted) return;
    if (idx + 1 >= LINE_CHARS) begin
      post_status(ihp_pkg::ST_LONG);
      return;
    end
    if (idx == 0) begin
      if (c != ihp_pkg::COLON_CHAR) begin
        post_status(ihp_pkg::ST_NOCOLON);
      end else begin
        line_pos  = 9'd1;
        range_hit = 1'b0;
      end
      return;
    end
    if (c == ihp_pkg::NEWLINE_CHAR) begin
      line_pos = '0;
      if (idx < 11 + 2 * int'(byte_count)) begin
        post_status(ihp_pkg::ST_SHORT);
      end else if (rec_type == 8'd1) begin
        post_status(ihp_pkg::ST_END);
      end else if (rec_type != 8'd0) begin
        post_status(ihp_pkg::ST_BADTYPE);
      end else if (range_hit) begin
        post_status(ihp_pkg::ST_RANGE);
      end else begin
        line_end = int'(load_addr) + int'(byte_count);
        if (line_end > IMAGE_BYTES) line_end = IMAGE_BYTES;
        if (line_end > int'(extent)) extent = ihp_pkg::ext_t'(line_end);
        post_status(ihp_pkg::ST_OK);
      end
      return;
    end
    line_pos = 9'(idx + 1);
    if (idx % 2 == 1) begin
      upper_nib = hex_value(c);
      return;
    end
    pair = int'({upper_nib, hex_value(c)});
    case (idx)
      2: byte_count = 8'(pair);
      4: load_addr[15:8] = 8'(pair);
      6: load_addr[7:0] = 8'(pair);
      8: rec_type = 8'(pair);
      default: begin
        if (idx >= 10 && idx < 10 + 2 * int'(byte_count) && rec_type == 8'd0) begin
          addr = int'(load_addr) + (idx - 10) / 2;
          if (addr >= IMAGE_BYTES) begin
            range_hit = 1'b1;
          end else if (!range_hit) begin
            result_words_due.push_back(ihp_pkg::rec_t'{kind: ihp_pkg::KIND_WRITE,
                                         write_address: ihp_pkg::waddr_t'(addr),
                                         write_data: ihp_pkg::char_t'(pair),
                                         status: ihp_pkg::ST_OK,
                                         image_extent: extent});
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int seen);
    if (want != seen) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    ihp_pkg::rec_t due_w;
    if (!rst_n) begin
      line_pos   = '0;
      upper_nib  = '0;
      byte_count = '0;
      load_addr  = '0;
      rec_type   = '0;
      extent     = '0;
      range_hit  = 1'b0;
      halted     = 1'b0;
      result_words_due.delete();
    end else begin
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) parse_char(in_chan.char_code);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        if (result_words_due.size() == 0) begin
          $error("result word with none due: kind %0d status %0d", out_chan.kind,
                 out_chan.status);
          fails++;
        end else begin
          due_w = result_words_due.pop_front();
          check_field("kind", int'(due_w.kind), int'(out_chan.kind));
          check_field("write_address", int'(due_w.write_address), int'(out_chan.write_address));
          check_field("write_data", int'(due_w.write_data), int'(out_chan.write_data));
          check_field("status", int'(due_w.status), int'(out_chan.status));
          check_field("image_extent", int'(due_w.image_extent), int'(out_chan.image_extent));
          if (due_w.kind == ihp_pkg::KIND_WRITE) writes++;
          else statuses++;
        end
      end
    end
    due_n <= result_words_due.size();
  end

endmodule

// ----- dv/tb_intel_hex_record_parser_core.sv -----
// ----------------------------------------------------------------------------
// tb_intel_hex_record_parser_core
// Feeds the HEX record parser a stream of text: a couple of hand-written lines,
// then a long run of well-formed data records with random addresses, counts,
// letter case and junk characters, and one closing line that ends the parse
// (end record or one of the error cases, picked at random). Sender bursts and
// receiver stalls vary over the run; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb_intel_hex_record_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1100;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic drain_open = 1'b0;

  ihp_char_if in_chan ();
  ihp_rec_if  out_chan ();

  int fail_count;
  int words_due;
  int writes_seen;
  int status_seen;
  int chars_sent  = 0;
  int lines_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rx_cycle    = 0;

  ihp_pkg::char_t   line_text[$];
  ihp_pkg::status_t finale_status;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  intel_hex_record_parser_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ihp_parser_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .fail_count  (fail_count),
    .words_due   (words_due),
    .writes_seen (writes_seen),
    .status_seen (status_seen)
  );

  // receiver: stall behavior steps through four modes picked by rx_cycle[8:7]
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (drain_open) begin
      out_chan.ready <= 1'b1;
    end else begin
      case (rx_cycle[8:7])
        2'd0: out_chan.ready <= 1'b1;
        2'd1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_chan.ready <= 1'($urandom_range(0, 1));
        default: out_chan.ready <= ((rx_cycle % 7) > 1);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_intel_hex_record_parser_core NOT OK");
      $finish;
    end
  end

  task automatic send_char(input ihp_pkg::char_t c);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 16);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    burst_left--;
    chars_sent++;
  endtask

  task automatic wait_for_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic send_line();
    foreach (line_text[i]) send_char(line_text[i]);
    lines_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(ihp_pkg::char_t'(s[i]));
    lines_sent++;
  endtask

  function automatic ihp_pkg::char_t hex_digit(input logic [3:0] n);
    if (n < 4'd10) return 8'd48 + 8'(n);
    return ($urandom_range(0, 1) ? 8'd55 : 8'd87) + 8'(n);
  endfunction

  function automatic ihp_pkg::char_t junk_char();
    ihp_pkg::char_t c;
    do c = 8'($urandom_range(0, 255)); while (c == ihp_pkg::NEWLINE_CHAR);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    line_text.push_back(hex_digit(b[7:4]));
    line_text.push_back(hex_digit(b[3:0]));
  endtask

  // one full record line with a proper checksum; junk lands in data, checksum, tail
  task automatic build_record(input int count, input int addr, input int rtype,
                              input int junk_pct);
    logic [7:0] sum;
    logic [7:0] b;
    line_text = {};
    line_text.push_back(ihp_pkg::COLON_CHAR);
    sum = 8'(count + (addr >> 8) + addr + rtype);
    push_byte(8'(count));
    push_byte(8'(addr >> 8));
    push_byte(8'(addr));
    push_byte(8'(rtype));
    repeat (count) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      push_byte(b);
    end
    push_byte(~sum + 8'd1);
    for (int i = 9; i < line_text.size(); i++)
      if ($urandom_range(0, 99) < junk_pct) line_text[i] = junk_char();
    repeat ($urandom_range(0, 2)) line_text.push_back($urandom_range(0, 1) ? 8'd13 : junk_char());
    line_text.push_back(ihp_pkg::NEWLINE_CHAR);
  endtask

  initial begin
    int             count;
    int             addr;
    int             limit;
    int             cut;
    ihp_pkg::char_t c;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.char_code  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mixed case, 0xFF/0x00 data, CR before LF, high-bit and non-hex chars
    send_text(":02000000ff00FF\015\n");
    send_text(":01001000\200z\3770\n");

    while (chars_sent < RANDOM_CHARS) begin
      cut = $urandom_range(0, 99);
      if (cut < 70) count = $urandom_range(0, 8);
      else if (cut < 95) count = $urandom_range(9, 32);
      else count = $urandom_range(33, 100);
      limit = 64 * (lines_sent + 1);
      if (limit > ihp_pkg::IMAGE_BYTES_DEF - count) limit = ihp_pkg::IMAGE_BYTES_DEF - count;
      if ($urandom_range(0, 9) == 0) addr = $urandom_range(0, ihp_pkg::IMAGE_BYTES_DEF - count);
      else addr = $urandom_range(0, limit);
      build_record(count, addr, 0, ($urandom_range(0, 3) == 0) ? 20 : 0);
      send_line();
      if ($urandom_range(0, 15) == 0) wait_for_results();
    end

    wait_for_results();
    if ($urandom_range(0, 1)) begin
      build_record(1, ihp_pkg::IMAGE_BYTES_DEF - 1, 0, 0);
      send_line();
    end
    if ($urandom_range(0, 1)) begin
      build_record(0, $urandom_range(ihp_pkg::IMAGE_BYTES_DEF, 16'hFFFF), 0, 0);
      send_line();
    end

    finale_status = ihp_pkg::status_t'($urandom_range(1, 6));
    case (finale_status)
      ihp_pkg::ST_END: build_record($urandom_range(0, 4), $urandom_range(0, 16'hFFFF), 1, 0);
      ihp_pkg::ST_NOCOLON: begin
        do c = junk_char(); while (c == ihp_pkg::COLON_CHAR);
        line_text = {};
        line_text.push_back(($urandom_range(0, 2) == 0) ? ihp_pkg::NEWLINE_CHAR : c);
        line_text.push_back(ihp_pkg::NEWLINE_CHAR);
      end
      ihp_pkg::ST_BADTYPE: build_record($urandom_range(0, 4), $urandom_range(0, 16'hFFFF),
                                        $urandom_range(2, 255), 0);
      ihp_pkg::ST_LONG: build_record($urandom_range(123, 255), 0, 0, 10);
      ihp_pkg::ST_RANGE: begin
        count = $urandom_range(1, 8);
        build_record(count, $urandom_range(ihp_pkg::IMAGE_BYTES_DEF + 1 - count, 16'hFFFF),
                     0, 0);
      end
      default: begin
        count = $urandom_range(0, 6);
        build_record(count, $urandom_range(0, ihp_pkg::IMAGE_BYTES_DEF - count), 0, 0);
        cut = $urandom_range(0, 9 + 2 * count);
        line_text = line_text[0:cut];
        line_text.push_back(ihp_pkg::NEWLINE_CHAR);
      end
    endcase
    send_line();
    // parser has stopped; these must draw no result
    repeat (6) send_char(8'($urandom_range(0, 255)));

    wait_for_results();
    drain_open <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d characters in %0d lines; checked %0d image writes and %0d status words",
             chars_sent, lines_sent, writes_seen, status_seen);
    $display("Parse closed by a %s line, followed by characters after the stop",
             finale_status.name());
    if (fail_count == 0 && words_due == 0) begin
      $display("tb_intel_hex_record_parser_core OK");
    end else begin
      $display("tb_intel_hex_record_parser_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ihp_pkg.sv
rtl/ihp_if.sv
rtl/ihp_step.sv
rtl/intel_hex_record_parser_core.sv
rtl/ihp_checker.sv
dv/ihp_parser_checker.sv
dv/tb_intel_hex_record_parser_core.sv
